@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each use expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Assertion on the house clock and reset names.
`define ASSERT_ON(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

@@ hdl/absuc_pkg.sv @@
// ----------------------------------------------------------------------------
// absuc_pkg
// Shared types and codes for the A/B slot update controller: event opcodes,
// phase encoding, and the request, state and response records.
// ----------------------------------------------------------------------------
`default_nettype none

package absuc_pkg;

	// Event opcodes; codes above OP_QUERY behave as a query
	localparam logic [3:0] OP_BEGIN    = 4'd0;
	localparam logic [3:0] OP_FINISH   = 4'd1;
	localparam logic [3:0] OP_VERIFY   = 4'd2;
	localparam logic [3:0] OP_COMMIT   = 4'd3;
	localparam logic [3:0] OP_REBOOT   = 4'd4;
	localparam logic [3:0] OP_HEALTH   = 4'd5;
	localparam logic [3:0] OP_ROLLBACK = 4'd6;
	localparam logic [3:0] OP_ABORT    = 4'd7;
	localparam logic [3:0] OP_RECOVER  = 4'd8;
	localparam logic [3:0] OP_QUERY    = 4'd9;

	// Update phases, in the order an update walks through them
	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_DOWNLOADING = 3'd1,
		PH_VERIFYING   = 3'd2,
		PH_COMMIT_PEND = 3'd3,
		PH_REBOOTING   = 3'd4,
		PH_HEALTHY     = 3'd5,
		PH_REVERTED    = 3'd6
	} phase_t;

	// One event request as captured from the input channel
	typedef struct packed {
		logic [3:0] op;
		logic       flag;
		logic [7:0] reason;
		logic       rec_run_slot;
		logic       rec_new_slot;
		logic [2:0] rec_phase;
		logic       rec_committed;
		logic       rec_healthy;
	} absuc_evt_t;

	// Controller state
	typedef struct packed {
		logic       active;
		logic       target;
		phase_t     phase;
		logic       written;
		logic       image_good;
		logic       committed;
		logic       healthy;
		logic       reverted;
		logic [7:0] abort_code;
	} absuc_state_t;

	// One response record
	typedef struct packed {
		logic       ok;
		logic       boot_slot;
		logic [2:0] phase;
		logic       run_slot;
		logic       new_slot;
		logic       committed;
		logic       written;
		logic       image_good;
		logic       healthy_boot;
		logic       was_reverted;
		logic [7:0] last_abort;
	} absuc_rsp_t;

endpackage

`default_nettype wire

@@ hdl/absuc_ifs.sv @@
// ----------------------------------------------------------------------------
// absuc_ifs
// Valid/ready channel interfaces: event requests in, status responses out.
// ----------------------------------------------------------------------------
`default_nettype none

interface absuc_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] op;
	logic       flag;
	logic [7:0] reason;
	logic       rec_run_slot;
	logic       rec_new_slot;
	logic [2:0] rec_phase;
	logic       rec_committed;
	logic       rec_healthy;

	modport source (
		output valid, op, flag, reason, rec_run_slot, rec_new_slot,
			rec_phase, rec_committed, rec_healthy,
		input  ready
	);
	modport sink (
		input  valid, op, flag, reason, rec_run_slot, rec_new_slot,
			rec_phase, rec_committed, rec_healthy,
		output ready
	);
endinterface

interface absuc_rsp_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic       boot_slot;
	logic [2:0] phase;
	logic       run_slot;
	logic       new_slot;
	logic       committed;
	logic       written;
	logic       image_good;
	logic       healthy_boot;
	logic       was_reverted;
	logic [7:0] last_abort;

	modport source (
		output valid, ok, boot_slot, phase, run_slot, new_slot, committed,
			written, image_good, healthy_boot, was_reverted, last_abort,
		input  ready
	);
	modport sink (
		input  valid, ok, boot_slot, phase, run_slot, new_slot, committed,
			written, image_good, healthy_boot, was_reverted, last_abort,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/absuc_core.sv @@
// ----------------------------------------------------------------------------
// absuc_core
// Update state register and its next-state logic. Applies one event per
// cycle when fire is high and presents the response for that event.
// ----------------------------------------------------------------------------
`default_nettype none

module absuc_core
	import absuc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire absuc_evt_t evt,
	output absuc_state_t state,
	output absuc_rsp_t  rsp
);

	absuc_state_t state_q;
	absuc_state_t nxt;
	logic         ok;
	phase_t       rec_ph;

	// Fall back to the known-good slot; the healthy phase is final
	function automatic absuc_state_t roll_back(input absuc_state_t s);
		absuc_state_t r;
		r = s;
		if (s.phase != PH_HEALTHY) begin
			r.target    = s.active;
			r.written   = 1'b0;
			r.committed = 1'b0;
			r.healthy   = 1'b0;
			r.reverted  = 1'b1;
			r.phase     = PH_REVERTED;
		end
		return r;
	endfunction

	// Recovered phase seven saturates to rolled back
	assign rec_ph = (evt.rec_phase == 3'd7) ? PH_REVERTED : phase_t'(evt.rec_phase);

	// Event decode
	always_comb begin
		nxt = state_q;
		ok  = 1'b0;
		case (evt.op)
			OP_BEGIN: begin
				if (state_q.phase == PH_IDLE) begin
					nxt.target     = ~state_q.active;
					nxt.written    = 1'b0;
					nxt.image_good = 1'b0;
					nxt.committed  = 1'b0;
					nxt.phase      = PH_DOWNLOADING;
				end
			end
			OP_FINISH: begin
				if (state_q.phase == PH_DOWNLOADING) begin
					if (evt.flag) begin
						nxt.written = 1'b1;
						ok          = 1'b1;
					end else begin
						nxt = roll_back(state_q);
					end
				end
			end
			OP_VERIFY: begin
				if (state_q.phase == PH_DOWNLOADING) begin
					nxt.phase      = PH_VERIFYING;
					nxt.image_good = evt.flag;
					if (evt.flag) begin
						ok = 1'b1;
					end else begin
						nxt = roll_back(nxt);
					end
				end
			end
			OP_COMMIT: begin
				if (state_q.phase == PH_VERIFYING) begin
					if (state_q.written && state_q.image_good) begin
						nxt.committed = 1'b1;
						nxt.phase     = PH_COMMIT_PEND;
						ok            = 1'b1;
					end else begin
						nxt = roll_back(state_q);
					end
				end
			end
			OP_REBOOT: begin
				if (state_q.phase == PH_COMMIT_PEND) begin
					nxt.phase = PH_REBOOTING;
				end
			end
			OP_HEALTH: begin
				if (state_q.phase == PH_REBOOTING) begin
					if (evt.flag && state_q.committed) begin
						nxt.healthy = 1'b1;
						nxt.active  = state_q.target;
						nxt.phase   = PH_HEALTHY;
						ok          = 1'b1;
					end else begin
						nxt = roll_back(state_q);
					end
				end
			end
			OP_ROLLBACK: begin
				nxt = roll_back(state_q);
			end
			OP_ABORT: begin
				if (state_q.phase != PH_HEALTHY) begin
					nxt            = roll_back(state_q);
					nxt.abort_code = evt.reason;
				end
			end
			OP_RECOVER: begin
				nxt.active     = evt.rec_run_slot;
				nxt.target     = evt.rec_new_slot;
				nxt.phase      = rec_ph;
				nxt.committed  = evt.rec_committed;
				nxt.healthy    = evt.rec_healthy;
				nxt.abort_code = evt.reason;
				nxt.written    = (rec_ph >= PH_COMMIT_PEND);
				nxt.image_good = (rec_ph >= PH_COMMIT_PEND);
				nxt.reverted   = (rec_ph == PH_REVERTED);
			end
			default: begin
				// query and unused codes leave the state alone
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				active: 1'b0, target: 1'b0, phase: PH_IDLE, written: 1'b0,
				image_good: 1'b0, committed: 1'b0, healthy: 1'b0,
				reverted: 1'b0, abort_code: 8'd0
			};
		end else if (fire) begin
			state_q <= nxt;
		end
	end

	// Response reflects the state after the event
	always_comb begin
		rsp.ok           = ok;
		rsp.boot_slot    = (nxt.phase == PH_HEALTHY && nxt.committed) ?
			nxt.target : nxt.active;
		rsp.phase        = nxt.phase;
		rsp.run_slot     = nxt.active;
		rsp.new_slot     = nxt.target;
		rsp.committed    = nxt.committed;
		rsp.written      = nxt.written;
		rsp.image_good   = nxt.image_good;
		rsp.healthy_boot = nxt.healthy;
		rsp.was_reverted = nxt.reverted;
		rsp.last_abort   = nxt.abort_code;
	end

	assign state = state_q;

endmodule

`default_nettype wire

@@ hdl/ab_slot_update_controller.sv @@
// ----------------------------------------------------------------------------
// ab_slot_update_controller
// Two-slot (A/B) firmware update controller with valid/ready event input and
// one status response per event.
// ----------------------------------------------------------------------------
// Each request is one update event and yields exactly one response carrying
// the boot slot and the full controller state after the event. The block
// takes one request per cycle sustained while responses are not stalled;
// each event passes the request register, then the response register. The rate
// is set by the combinational next-state logic on the state register, which
// is updated as an event moves into the response register. A stalled
// response still leaves room for one more request in the request register.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_slot_update_controller
	import absuc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	absuc_req_if.sink   req,
	absuc_rsp_if.source rsp
);

	`include "assert_macros.svh"

	logic         vld_s1;
	absuc_evt_t   evt_s1;
	logic         vld_s2;
	absuc_rsp_t   rsp_s2;
	logic         adv;
	absuc_state_t state;
	absuc_rsp_t   rsp_d;

	// Stage 1 moves on when the response register is free or draining
	assign adv       = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			evt_s1 <= '{
				op: req.op, flag: req.flag, reason: req.reason,
				rec_run_slot: req.rec_run_slot,
				rec_new_slot: req.rec_new_slot,
				rec_phase: req.rec_phase, rec_committed: req.rec_committed,
				rec_healthy: req.rec_healthy
			};
		end
	end

	absuc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.evt    (evt_s1),
		.state  (state),
		.rsp    (rsp_d)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid        = vld_s2;
	assign rsp.ok           = rsp_s2.ok;
	assign rsp.boot_slot    = rsp_s2.boot_slot;
	assign rsp.phase        = rsp_s2.phase;
	assign rsp.run_slot     = rsp_s2.run_slot;
	assign rsp.new_slot     = rsp_s2.new_slot;
	assign rsp.committed    = rsp_s2.committed;
	assign rsp.written      = rsp_s2.written;
	assign rsp.image_good   = rsp_s2.image_good;
	assign rsp.healthy_boot = rsp_s2.healthy_boot;
	assign rsp.was_reverted = rsp_s2.was_reverted;
	assign rsp.last_abort   = rsp_s2.last_abort;

	// Healthy is final except for a recover event
	`ASSERT_ON(a_healthy_sticky,
		adv && state.phase == PH_HEALTHY && evt_s1.op != OP_RECOVER
			|=> state.phase == PH_HEALTHY,
		"healthy phase left without recover")

	// Rolled back is left only by recover
	`ASSERT_ON(a_reverted_sticky,
		adv && state.phase == PH_REVERTED && evt_s1.op != OP_RECOVER
			|=> state.phase == PH_REVERTED,
		"rolled back phase left without recover")

	// No event is applied while its response cannot be stored
	`ASSERT_ON(a_state_holds_on_stall,
		vld_s2 && !rsp.ready |=> $stable(state),
		"state changed while response stalled")

	// Boot slot follows the reported phase and slots
	`ASSERT_ON(a_boot_slot,
		vld_s2 |-> rsp.boot_slot == ((rsp.phase == PH_HEALTHY && rsp.committed) ?
			rsp.new_slot : rsp.run_slot),
		"boot slot inconsistent with reported state")

endmodule

`default_nettype wire
